[src/psarl_pkg.sv]
// ----------------------------------------------------------------------------
// psarl_pkg
// Shared types and constants of the per-source accept rate limiter: the
// controller state, the command and status groups, and register indexes.
// ----------------------------------------------------------------------------
package psarl_pkg;

    localparam int BUCKET_SLOTS_DEF = 16;

    localparam int FAMILY_W = 2;
    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FAMILY_W-1:0] FAMILY_NONE = 2'd0;
    localparam logic [FAMILY_W-1:0] FAMILY_IPV4 = 2'd1;
    localparam logic [FAMILY_W-1:0] FAMILY_IPV6 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 2'd1;

    localparam logic [TIME_W-1:0]  WINDOW_LENGTH_RESET  = 32'd1000;
    localparam logic [COUNT_W-1:0] MAX_PER_WINDOW_RESET = 16'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_INSERT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_req;
        logic scan_step;
        logic do_update;
        logic do_insert;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic req_special;
        logic hit;
        logic last;
        logic out_busy;
    } status_t;

endpackage

[src/per_source_accept_rate_limiter_core.sv]
// ----------------------------------------------------------------------------
// per_source_accept_rate_limiter_core
// Fixed-window connection rate limiter keyed by source address.
// ----------------------------------------------------------------------------
// Each request transaction carries an address family, a 128-bit source
// address and a millisecond timestamp; one result transaction answers
// allow (1) or deny (0). The block holds BUCKET_SLOTS buckets and walks
// them one slot per cycle through a single compare/elapsed-time unit, so a
// request that matches a slot ends the walk there and updates its bucket,
// a new address walks every slot and is then inserted, and an unspecified
// address (family none, unknown family or an all-zero address) skips the
// walk and leaves the table untouched. One request is in work at a time;
// a finished result sits in an output register, so the next request is
// taken while the sink still stalls. Reset empties the table at once.
// The user must write window_length (index 0) and max_per_window (index 1)
// on the cfg port only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module per_source_accept_rate_limiter_core
#(
    parameter int BUCKET_SLOTS = psarl_pkg::BUCKET_SLOTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [psarl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psarl_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [psarl_pkg::FAMILY_W-1:0]    addr_family,
    input  logic [psarl_pkg::ADDR_W-1:0]      addr_high,
    input  logic [psarl_pkg::ADDR_W-1:0]      addr_low,
    input  logic [psarl_pkg::TIME_W-1:0]      now_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              allowed
);

    // commands from the sequencer, status back from the datapath
    psarl_pkg::cmd_t    cmd;
    psarl_pkg::status_t sts;

    // sequencer: accept, walk the table, write back, hand off the result
    psarl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: registers, bucket table, scan trackers, output register
    psarl_dpath
    #(
        .BUCKET_SLOTS (BUCKET_SLOTS)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .addr_family (addr_family),
        .addr_high   (addr_high),
        .addr_low    (addr_low),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .allowed     (allowed),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

[src/psarl_ctrl.sv]
// ----------------------------------------------------------------------------
// psarl_ctrl
// Rate limiter sequencer: takes a transaction, walks the table one slot
// per cycle, updates or inserts, hands it on; specials skip walk and write.
// ----------------------------------------------------------------------------
module psarl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  psarl_pkg::status_t sts,
    output psarl_pkg::cmd_t    cmd
);

    psarl_pkg::state_t state_reg;
    psarl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psarl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            psarl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = sts.req_special ? psarl_pkg::ST_FINISH
                                                   : psarl_pkg::ST_SCAN;
                end
            end
            psarl_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    state_next = psarl_pkg::ST_UPDATE;
                end
                else if (sts.last)
                begin
                    state_next = psarl_pkg::ST_INSERT;
                end
            end
            psarl_pkg::ST_UPDATE:
            begin
                cmd.do_update = 1'b1;
                state_next    = psarl_pkg::ST_FINISH;
            end
            psarl_pkg::ST_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = psarl_pkg::ST_FINISH;
            end
            psarl_pkg::ST_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = psarl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psarl_pkg::ST_IDLE;
            end
        endcase
    end

    // never overwrite a result that the sink still holds
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded while output held");

    // unspecified address skips the table walk
    a_special_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_req && sts.req_special) |=> (state_reg == psarl_pkg::ST_FINISH))
        else $error("special request entered table walk");

    // a miss on the last slot always inserts
    a_miss_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psarl_pkg::ST_SCAN && sts.last && !sts.hit)
        |=> (state_reg == psarl_pkg::ST_INSERT))
        else $error("table walk ended without insert");

    // table writes are followed by the result hand-off
    a_write_then_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_update || cmd.do_insert) |=> (state_reg == psarl_pkg::ST_FINISH))
        else $error("table write not followed by finish");

endmodule

[src/psarl_dpath.sv]
// ----------------------------------------------------------------------------
// psarl_dpath
// Datapath of the rate limiter: configuration registers, request capture,
// bucket table, scan trackers and the output register.
// ----------------------------------------------------------------------------
module psarl_dpath
#(
    parameter int BUCKET_SLOTS = psarl_pkg::BUCKET_SLOTS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psarl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psarl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [psarl_pkg::FAMILY_W-1:0]      addr_family,
    input  logic [psarl_pkg::ADDR_W-1:0]        addr_high,
    input  logic [psarl_pkg::ADDR_W-1:0]        addr_low,
    input  logic [psarl_pkg::TIME_W-1:0]        now_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                allowed,
    input  psarl_pkg::cmd_t                     cmd,
    output psarl_pkg::status_t                  sts
);

    localparam int IDX_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_SLOTS - 1);

    // configuration
    logic [psarl_pkg::TIME_W-1:0]  window_length_reg;
    logic [psarl_pkg::COUNT_W-1:0] max_per_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg  <= psarl_pkg::WINDOW_LENGTH_RESET;
            max_per_window_reg <= psarl_pkg::MAX_PER_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == psarl_pkg::REG_WINDOW_LENGTH)
            begin
                window_length_reg <= cfg_data;
            end
            else if (cfg_index == psarl_pkg::REG_MAX_PER_WINDOW)
            begin
                max_per_window_reg <= cfg_data[psarl_pkg::COUNT_W-1:0];
            end
        end
    end

    // request capture; IPv4 keeps only the low 32 address bits
    logic [psarl_pkg::ADDR_W-1:0] norm_high;
    logic [psarl_pkg::ADDR_W-1:0] norm_low;

    always_comb
    begin
        norm_high = addr_high;
        norm_low  = addr_low;
        if (addr_family == psarl_pkg::FAMILY_IPV4)
        begin
            norm_high = '0;
            norm_low  = {32'd0, addr_low[31:0]};
        end
    end

    assign sts.req_special = ((addr_family != psarl_pkg::FAMILY_IPV4) &&
                              (addr_family != psarl_pkg::FAMILY_IPV6)) ||
                             ((norm_high == '0) && (norm_low == '0));

    logic [psarl_pkg::FAMILY_W-1:0] req_family_reg;
    logic [psarl_pkg::ADDR_W-1:0]   req_high_reg;
    logic [psarl_pkg::ADDR_W-1:0]   req_low_reg;
    logic [psarl_pkg::TIME_W-1:0]   req_now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_family_reg <= addr_family;
            req_high_reg   <= norm_high;
            req_low_reg    <= norm_low;
            req_now_reg    <= now_ms;
        end
    end

    // bucket table
    logic [psarl_pkg::FAMILY_W-1:0] bucket_family_reg [BUCKET_SLOTS];
    logic [psarl_pkg::ADDR_W-1:0]   bucket_high_reg   [BUCKET_SLOTS];
    logic [psarl_pkg::ADDR_W-1:0]   bucket_low_reg    [BUCKET_SLOTS];
    logic [psarl_pkg::TIME_W-1:0]   bucket_start_reg  [BUCKET_SLOTS];
    logic [psarl_pkg::COUNT_W-1:0]  bucket_count_reg  [BUCKET_SLOTS];

    // scan state
    logic [IDX_W-1:0]              scan_idx_reg;
    logic                          empty_found_reg;
    logic [IDX_W-1:0]              empty_idx_reg;
    logic                          exp_found_reg;
    logic [IDX_W-1:0]              exp_idx_reg;
    logic [IDX_W-1:0]              victim_idx_reg;
    logic [psarl_pkg::TIME_W-1:0]  best_elapsed_reg;
    logic [IDX_W-1:0]              hit_idx_reg;
    logic                          hit_exp_reg;

    logic [psarl_pkg::FAMILY_W-1:0] cur_family;
    logic [psarl_pkg::TIME_W-1:0]   cur_elapsed;
    logic                           cur_expired;

    assign cur_family  = bucket_family_reg[scan_idx_reg];
    assign cur_elapsed = req_now_reg - bucket_start_reg[scan_idx_reg];
    assign cur_expired = (cur_elapsed >= window_length_reg);

    assign sts.hit  = (cur_family != psarl_pkg::FAMILY_NONE) &&
                      (cur_family == req_family_reg) &&
                      (bucket_high_reg[scan_idx_reg] == req_high_reg) &&
                      (bucket_low_reg[scan_idx_reg] == req_low_reg);
    assign sts.last = (scan_idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            empty_found_reg <= 1'b0;
            exp_found_reg   <= 1'b0;
        end
        else if (cmd.load_req)
        begin
            scan_idx_reg    <= '0;
            empty_found_reg <= 1'b0;
            exp_found_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            if (cur_family == psarl_pkg::FAMILY_NONE)
            begin
                empty_found_reg <= 1'b1;
            end
            else if (cur_expired)
            begin
                exp_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            hit_idx_reg <= scan_idx_reg;
            hit_exp_reg <= cur_expired;
            if (cur_family == psarl_pkg::FAMILY_NONE && !empty_found_reg)
            begin
                empty_idx_reg <= scan_idx_reg;
            end
            if (cur_family != psarl_pkg::FAMILY_NONE && cur_expired && !exp_found_reg)
            begin
                exp_idx_reg <= scan_idx_reg;
            end
            // victim search starts at slot zero; move only on a strictly older window
            if (scan_idx_reg == '0)
            begin
                victim_idx_reg   <= '0;
                best_elapsed_reg <= cur_elapsed;
            end
            else if (cur_family != psarl_pkg::FAMILY_NONE &&
                     cur_elapsed > best_elapsed_reg)
            begin
                victim_idx_reg   <= scan_idx_reg;
                best_elapsed_reg <= cur_elapsed;
            end
        end
    end

    // update of a matching bucket
    logic [psarl_pkg::COUNT_W-1:0] upd_count_base;
    logic                          upd_deny;
    logic [psarl_pkg::COUNT_W-1:0] upd_count;
    logic [IDX_W-1:0]              ins_idx;

    assign upd_count_base = hit_exp_reg ? '0 : bucket_count_reg[hit_idx_reg];
    assign upd_deny       = (upd_count_base >= max_per_window_reg);
    assign upd_count      = upd_deny ? upd_count_base
                                     : upd_count_base + psarl_pkg::COUNT_W'(1);
    assign ins_idx        = empty_found_reg ? empty_idx_reg :
                            exp_found_reg   ? exp_idx_reg   : victim_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKET_SLOTS; i++)
            begin
                bucket_family_reg[i] <= psarl_pkg::FAMILY_NONE;
            end
        end
        else if (cmd.do_insert)
        begin
            bucket_family_reg[ins_idx] <= req_family_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_update)
        begin
            if (hit_exp_reg)
            begin
                bucket_start_reg[hit_idx_reg] <= req_now_reg;
            end
            bucket_count_reg[hit_idx_reg] <= upd_count;
        end
        else if (cmd.do_insert)
        begin
            bucket_high_reg[ins_idx]  <= req_high_reg;
            bucket_low_reg[ins_idx]   <= req_low_reg;
            bucket_start_reg[ins_idx] <= req_now_reg;
            bucket_count_reg[ins_idx] <= psarl_pkg::COUNT_W'(1);
        end
    end

    // result and output register
    logic pending_allow_reg;
    logic out_valid_reg;
    logic allowed_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req || cmd.do_insert)
        begin
            pending_allow_reg <= 1'b1;
        end
        else if (cmd.do_update)
        begin
            pending_allow_reg <= !upd_deny;
        end
        if (cmd.load_out)
        begin
            allowed_reg <= pending_allow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_busy = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign allowed      = allowed_reg;

endmodule

[bench/per_source_accept_rate_limiter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_source_accept_rate_limiter_core_tb
// Self-checking bench for the per-source fixed-window accept rate limiter.
// ----------------------------------------------------------------------------
// A driver process offers connection request transactions from a pending
// queue, and a monitor process takes verdict transactions off the result
// channel. Every accepted request runs through a bucket-table predictor kept
// inside this bench, and the monitor compares each verdict with the oldest
// prediction. A short directed burst covers unspecified addresses, the
// limit, window expiry and timestamp wrap. Several random phases follow,
// each under its own window length and limit, the extremes among them,
// with a small hot set of addresses so that buckets hit, deny, expire and
// get evicted. Both sides idle at random, and the sink holds off once for a
// long stretch so that the block backs up into its request channel.
// ----------------------------------------------------------------------------
module per_source_accept_rate_limiter_core_tb;

    localparam int FAMILY_W   = psarl_pkg::FAMILY_W;
    localparam int ADDR_W     = psarl_pkg::ADDR_W;
    localparam int TIME_W     = psarl_pkg::TIME_W;
    localparam int COUNT_W    = psarl_pkg::COUNT_W;
    localparam int CFG_IDX_W  = psarl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = psarl_pkg::CFG_DATA_W;
    localparam logic [FAMILY_W-1:0]  FAMILY_NONE          = psarl_pkg::FAMILY_NONE;
    localparam logic [FAMILY_W-1:0]  FAMILY_IPV4          = psarl_pkg::FAMILY_IPV4;
    localparam logic [FAMILY_W-1:0]  FAMILY_IPV6          = psarl_pkg::FAMILY_IPV6;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = psarl_pkg::REG_WINDOW_LENGTH;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW   = psarl_pkg::REG_MAX_PER_WINDOW;
    localparam logic [TIME_W-1:0]    WINDOW_LENGTH_RESET  = psarl_pkg::WINDOW_LENGTH_RESET;
    localparam logic [COUNT_W-1:0]   MAX_PER_WINDOW_RESET = psarl_pkg::MAX_PER_WINDOW_RESET;

    localparam int SLOTS = psarl_pkg::BUCKET_SLOTS_DEF;
    // Watchdog: cycles without any transaction before the run is declared hung.
    // The limit must outlast the long sink hold-off and a full table walk.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_RESULT = 250;
    // Family code outside the defined set; the block must treat it as none.
    localparam logic [FAMILY_W-1:0] FAMILY_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [FAMILY_W-1:0] family;
        logic [ADDR_W-1:0]   hi;
        logic [ADDR_W-1:0]   lo;
        logic [TIME_W-1:0]   stamp;
    } conn_req_t;

    // DUT connections; every input is known from time zero
    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [FAMILY_W-1:0]   addr_family = '0;
    logic [ADDR_W-1:0]     addr_high   = '0;
    logic [ADDR_W-1:0]     addr_low    = '0;
    logic [TIME_W-1:0]     now_ms      = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic                  allowed;

    // Shadow of the bucket table and of the two registers
    logic [FAMILY_W-1:0]   bkt_family [SLOTS];
    logic [ADDR_W-1:0]     bkt_hi     [SLOTS];
    logic [ADDR_W-1:0]     bkt_lo     [SLOTS];
    logic [TIME_W-1:0]     bkt_start  [SLOTS];
    logic [COUNT_W-1:0]    bkt_count  [SLOTS];
    logic [TIME_W-1:0]     window_cfg;
    logic [COUNT_W-1:0]    limit_cfg;

    conn_req_t             pending_reqs[$];
    logic                  expected_verdicts[$];
    conn_req_t             next_req;
    logic [TIME_W-1:0]     wall_ms;

    int                    err_cnt      = 0;
    int                    send_gap     = 0;
    bit                    send_burst   = 1'b0;
    int                    recv_wait    = 0;
    bit                    recv_burst   = 1'b0;
    int                    results_seen = 0;
    int                    hold_left    = 0;
    bit                    hold_done    = 1'b0;
    int                    quiet_cycles = 0;

    per_source_accept_rate_limiter_core #(
        .BUCKET_SLOTS (SLOTS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .addr_family (addr_family),
        .addr_high   (addr_high),
        .addr_low    (addr_low),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .allowed     (allowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Decide allow/deny for one request and advance the shadow table.
    function automatic logic predict_verdict(input logic [FAMILY_W-1:0] fam,
                                             input logic [ADDR_W-1:0] hi_in,
                                             input logic [ADDR_W-1:0] lo_in,
                                             input logic [TIME_W-1:0] stamp);
        logic [ADDR_W-1:0] hi;
        logic [ADDR_W-1:0] lo;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] victim_age;
        int                empty_slot;
        int                expired_slot;
        int                victim;
        int                slot;
        hi           = hi_in;
        lo           = lo_in;
        empty_slot   = -1;
        expired_slot = -1;
        victim       = 0;
        // IPv4 keys on the low 32 bits only; stray bits are dropped
        if (fam == FAMILY_IPV4)
        begin
            hi = '0;
            lo = {32'd0, lo_in[31:0]};
        end
        // Unspecified source: allow and leave the table alone
        if ((fam != FAMILY_IPV4 && fam != FAMILY_IPV6) || (hi == '0 && lo == '0))
            return 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            age = stamp - bkt_start[i];
            if (bkt_family[i] != FAMILY_NONE && bkt_family[i] == fam &&
                bkt_hi[i] == hi && bkt_lo[i] == lo)
            begin
                if (age >= window_cfg)
                begin
                    bkt_start[i] = stamp;
                    bkt_count[i] = '0;
                end
                if (bkt_count[i] >= limit_cfg)
                    return 1'b0;
                bkt_count[i] = bkt_count[i] + 1'b1;
                return 1'b1;
            end
            if (bkt_family[i] == FAMILY_NONE)
            begin
                if (empty_slot < 0)
                    empty_slot = i;
            end
            else
            begin
                if (expired_slot < 0 && age >= window_cfg)
                    expired_slot = i;
                // strictly older only, so ties keep the lowest index
                victim_age = stamp - bkt_start[victim];
                if (age > victim_age)
                    victim = i;
            end
        end
        slot = (empty_slot >= 0) ? empty_slot : (expired_slot >= 0) ? expired_slot : victim;
        bkt_family[slot] = fam;
        bkt_hi[slot]     = hi;
        bkt_lo[slot]     = lo;
        bkt_start[slot]  = stamp;
        bkt_count[slot]  = 16'd1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic queue_request(input logic [FAMILY_W-1:0] fam,
                                 input logic [ADDR_W-1:0] hi,
                                 input logic [ADDR_W-1:0] lo,
                                 input logic [TIME_W-1:0] stamp);
        conn_req_t req;
        req.family = fam;
        req.hi     = hi;
        req.lo     = lo;
        req.stamp  = stamp;
        pending_reqs.push_back(req);
    endtask

    // Wait until every request has gone in and every verdict has come out.
    // Poll on the falling edge so the check never races the clocked processes.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_WINDOW_LENGTH)
            window_cfg = data;
        else if (idx == REG_MAX_PER_WINDOW)
            limit_cfg = data[COUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic over a small address pool. Entry 0 is hot so that its
    // bucket reaches the limit; a pool wider than the table forces eviction.
    task automatic queue_traffic(input int count, input int pool_size);
        logic [FAMILY_W-1:0] pool_fam [32];
        logic [ADDR_W-1:0]   pool_hi  [32];
        logic [ADDR_W-1:0]   pool_lo  [32];
        logic [TIME_W-1:0]   step;
        logic [FAMILY_W-1:0] fam;
        logic [ADDR_W-1:0]   hi;
        logic [ADDR_W-1:0]   lo;
        int                  pick;
        int                  r;
        for (int p = 0; p < pool_size; p++)
        begin
            r = $urandom_range(0, 3);
            pool_fam[p] = (r == 0) ? FAMILY_IPV4 : FAMILY_IPV6;
            pool_hi[p]  = (r >= 2) ? 64'd0 : {$urandom(), $urandom()};
            pool_lo[p]  = (r == 0) ? {32'd0, 32'($urandom_range(1, 32'hFFFF_FFFF))}
                        : (r == 2) ? 64'($urandom_range(1, 8))
                        : (r == 3) ? {32'd0, $urandom()} | 64'd1
                        : {$urandom(), $urandom()};
        end
        for (int k = 0; k < count; k++)
        begin
            // advance the clock: mostly short hops, some near the window,
            // now and then a full wrap or a jump anywhere
            r = $urandom_range(0, 99);
            if (r < 20)
                step = '0;
            else if (r < 75)
                step = $urandom_range(0, (window_cfg >> 6) + 1);
            else if (r < 90)
                step = $urandom_range(0, window_cfg);
            else if (r < 94)
                step = window_cfg;
            else if (r < 97)
                step = 32'hFFFF_FFFF;
            else
                step = $urandom();
            wall_ms = wall_ms + step;

            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                pick = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, pool_size - 1);
                fam  = pool_fam[pick];
                hi   = pool_hi[pick];
                lo   = pool_lo[pick];
                // IPv4 stray bits must not matter
                if (fam == FAMILY_IPV4)
                begin
                    hi = {$urandom(), $urandom()};
                    lo = {$urandom(), pool_lo[pick][31:0]};
                end
            end
            else
            begin
                hi = {$urandom(), $urandom()};
                lo = {$urandom(), $urandom()};
                case ($urandom_range(0, 4))
                    0: fam = FAMILY_NONE;
                    1: fam = FAMILY_UNKNOWN;
                    2:
                    begin
                        fam = FAMILY_IPV6;
                        hi  = '0;
                        lo  = '0;
                    end
                    3:
                    begin
                        fam = FAMILY_IPV4;
                        lo  = {lo[63:32], 32'd0};
                    end
                    default: fam = ($urandom_range(0, 1) != 0) ? FAMILY_IPV4 : FAMILY_IPV6;
                endcase
            end
            queue_request(fam, hi, lo, wall_ms);
        end
    endtask

    task automatic run_phase(input logic [TIME_W-1:0] window, input logic [COUNT_W-1:0] limit,
                             input int count, input int pool_size);
        settle();
        write_reg(REG_WINDOW_LENGTH, window);
        // upper data bits of the limit register are don't-care
        write_reg(REG_MAX_PER_WINDOW, {16'($urandom()), limit});
        queue_traffic(count, pool_size);
    endtask

    // Stimulus and phase sequencing
    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            bkt_family[i] = FAMILY_NONE;
            bkt_hi[i]     = '0;
            bkt_lo[i]     = '0;
            bkt_start[i]  = '0;
            bkt_count[i]  = '0;
        end
        window_cfg = WINDOW_LENGTH_RESET;
        limit_cfg  = MAX_PER_WINDOW_RESET;
        wall_ms    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at reset settings (window 1000, limit 10)
        // Unspecified sources: no family, unknown family, all-zero addresses
        queue_request(FAMILY_NONE, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 32'd5);
        queue_request(FAMILY_UNKNOWN, '1, '1, 32'd6);
        queue_request(FAMILY_IPV6, '0, '0, 32'd7);
        queue_request(FAMILY_IPV4, '1, 64'hFFFF_FFFF_0000_0000, 32'd8);
        // Same IPv4 source eleven times with changing stray bits: last denied
        for (int k = 0; k < 11; k++)
            queue_request(FAMILY_IPV4, {$urandom(), $urandom()},
                          {$urandom(), 32'hC0A8_0001}, 32'(100 + k));
        // One tick short of expiry still denies; at the boundary it restarts
        queue_request(FAMILY_IPV4, '0, 64'h0000_0000_C0A8_0001, 32'd1099);
        queue_request(FAMILY_IPV4, '0, 64'h0000_0000_C0A8_0001, 32'd1100);
        // Same bits under IPv6 are a different source
        queue_request(FAMILY_IPV6, '0, 64'h0000_0000_C0A8_0001, 32'd1200);
        // Elapsed time across the timestamp wrap
        queue_request(FAMILY_IPV6, '1, '1, 32'hFFFF_FFF0);
        queue_request(FAMILY_IPV6, '1, '1, 32'h0000_0010);
        wall_ms = 32'h0000_0010;

        // Random part
        queue_traffic(210, 3);
        run_phase(32'd0,          16'd0,     210, 6);
        run_phase(32'hFFFF_FFFF,  16'hFFFF,  210, 24);
        run_phase(32'd1,          16'd1,     210, 20);
        run_phase(32'd40,         16'd3,     210, 20);
        run_phase(32'd0,          16'd5,     200, 10);
        run_phase(32'd5000,       16'd2,     210, 17);

        settle();
        // drain: catch any stray verdict after the last expected one
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("per_source_accept_rate_limiter_core_tb: clean");
        else
            $display("per_source_accept_rate_limiter_core_tb: errors");
        $finish;
    end

    // Request driver: hold the payload while stalled, advance on acceptance,
    // and insert a random send_gap idle before each new transaction outside bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_verdicts.push_back(predict_verdict(addr_family, addr_high,
                                                            addr_low, now_ms));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    addr_family <= next_req.family;
                    addr_high   <= next_req.hi;
                    addr_low    <= next_req.lo;
                    now_ms      <= next_req.stamp;
                    in_valid    <= 1'b1;
                    if ($urandom_range(0, 40) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor and sink stall control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                    report_mismatch($sformatf("verdict %b with no request pending", allowed));
                else if (allowed !== expected_verdicts[0])
                    report_mismatch($sformatf("verdict #%0d allowed %b, predicted %b",
                                              results_seen, allowed, expected_verdicts[0]));
                if (expected_verdicts.size() != 0)
                    void'(expected_verdicts.pop_front());
                results_seen = results_seen + 1;
                if ($urandom_range(0, 40) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 3);
                // once, hold off long enough for the block to back up
                if (!hold_done && results_seen == HOLD_AT_RESULT)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait = recv_wait - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no transaction of any kind moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("per_source_accept_rate_limiter_core_tb: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
